>>> rtl/core/decimal_text_to_fixed_point_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for decimal_text_to_fixed_point
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH

`ifndef ASSERT_OFF
`define DTFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DTFP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define DTFP_ASSERT(lbl, prop, msg)
`define DTFP_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> rtl/core/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared widths, power-of-ten table and the parse job record.
// ----------------------------------------------------------------------------
package dtfp_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int MAX_DECIMAL_EXP = 18;

	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 48;
	localparam int FDIG_W   = 5;
	localparam int FDIG_MAX = 31;
	localparam int EXPM_W   = 7;
	localparam int EXPM_MAX = 127;

	// log2(10) < 10/3, log10(2) < 1/3
	localparam int MANT_W = MAX_DECIMAL_EXP * 10 / 3 + 1;
	localparam int K_MAX  = MAX_DECIMAL_EXP + FRAC_BITS / 3 + 1;
	localparam int KI_W   = $clog2(K_MAX + 1);
	localparam int DIV_W  = K_MAX * 10 / 3 + 1;
	localparam int NUM_W  = MANT_W + FRAC_BITS;
	localparam int ACC_W  = (NUM_W > VALUE_W) ? NUM_W : VALUE_W;
	localparam int CNT_W  = ($clog2(ACC_W + 1) > EXPM_W) ? $clog2(ACC_W + 1) : EXPM_W;
	localparam int EXP_W  = EXPM_W + 2;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef logic [DIV_W-1:0] pow10_t;
	typedef pow10_t pow10_tab_t [K_MAX+1];

	function automatic pow10_tab_t make_pow10();
		pow10_tab_t t;
		t[0] = pow10_t'(1);
		for (int i = 1; i <= K_MAX; i++) begin
			t[i] = t[i-1] * pow10_t'(10);
		end
		return t;
	endfunction

	localparam pow10_tab_t POW10 = make_pow10();
	localparam logic [MANT_W-1:0] MANT_LIM = POW10[MAX_DECIMAL_EXP-1][MANT_W-1:0];

	typedef struct packed {
		logic                neg;
		logic                ovf;
		logic                exp_neg;
		logic [EXPM_W-1:0]   exp_mag;
		logic [FDIG_W-1:0]   frac_dig;
		logic [MANT_W-1:0]   mant;
	} job_t;

endpackage

>>> rtl/core/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Decimal text in, one character per transfer; signed fixed point out.
//
//  channel | dir | tdata            | tuser      | tlast
//  s_      | in  | [7:0] char_code  | -          | last_char
//  m_      | out | [47:0] value     | saturated  | -
//
// Parser takes one character per cycle unless the 2-entry job queue behind
// it is full. Scaler per string: a zero or overflowed mantissa goes straight
// to ST_FIN, a non-negative decimal exponent uses iterated x10 (ends early on
// saturation), a negative one the one-bit-per-cycle restoring divider.
// Reset clears all control state; no clearing pass.
// s_tready drops only while the job queue is full.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [47:0] value
	output logic        m_tuser    // [0] saturated
);

	logic              take;
	logic              push;
	logic              full;
	logic              pop;
	logic              job_valid;
	dtfp_pkg::job_t    job_in;
	dtfp_pkg::job_t    job_out;

	assign s_tready = !full;
	assign take     = s_tvalid && !full;

	dtfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (s_tdata),
		.last_char (s_tlast),
		.push      (push),
		.job       (job_in)
	);

	dtfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.job_in    (job_in),
		.full      (full),
		.pop       (pop),
		.job_valid (job_valid),
		.job_out   (job_out)
	);

	dtfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_out),
		.pop       (pop),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.value     (m_tdata),
		.saturated (m_tuser)
	);

endmodule

>>> rtl/core/dtfp_front.sv
// ----------------------------------------------------------------------------
// dtfp_front
// Character parser: sign, digits, point, exponent; emits one job per string.
// ----------------------------------------------------------------------------
module dtfp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [dtfp_pkg::CHAR_W-1:0]     char_code,
	input  logic                            last_char,
	output logic                            push,
	output dtfp_pkg::job_t                  job
);

	localparam logic [dtfp_pkg::CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [dtfp_pkg::CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [dtfp_pkg::CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [dtfp_pkg::CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [dtfp_pkg::CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [dtfp_pkg::CHAR_W-1:0] CH_E_LO  = 8'h65;
	localparam logic [dtfp_pkg::CHAR_W-1:0] CH_E_UP  = 8'h45;
	localparam int EM_W = dtfp_pkg::EXPM_W + 4;

	typedef enum logic [2:0] {
		PH_SIGN,
		PH_INT,
		PH_FRAC,
		PH_ESIGN,
		PH_EDIG,
		PH_STOP
	} phase_t;

	phase_t                           phase_q, phase_nx;
	logic                             neg_q, neg_nx;
	logic [dtfp_pkg::MANT_W-1:0]      mant_q, mant_nx;
	logic [dtfp_pkg::FDIG_W-1:0]      fd_q, fd_nx;
	logic                             eneg_q, eneg_nx;
	logic [dtfp_pkg::EXPM_W-1:0]      emag_q, emag_nx;
	logic                             ovf_q, ovf_nx;

	always_comb begin
		logic                         is_dig;
		logic                         sign_ch;
		logic                         exp_ch;
		logic [3:0]                   dig;
		logic                         mant_ok;
		logic [dtfp_pkg::MANT_W-1:0]  mant_push;
		logic [EM_W-1:0]              emag_calc;

		is_dig    = (char_code >= CH_0) && (char_code <= CH_9);
		sign_ch   = (char_code == CH_MINUS) || (char_code == CH_PLUS);
		exp_ch    = (char_code == CH_E_LO) || (char_code == CH_E_UP);
		dig       = char_code[3:0];
		mant_ok   = mant_q < dtfp_pkg::MANT_LIM;
		mant_push = (mant_q << 3) + (mant_q << 1) + dtfp_pkg::MANT_W'(dig);
		emag_calc = (EM_W'(emag_q) << 3) + (EM_W'(emag_q) << 1) + EM_W'(dig);

		phase_nx = phase_q;
		neg_nx   = neg_q;
		mant_nx  = mant_q;
		fd_nx    = fd_q;
		eneg_nx  = eneg_q;
		emag_nx  = emag_q;
		ovf_nx   = ovf_q;

		unique case (phase_q) inside
			PH_SIGN, PH_INT: begin
				if (phase_q == PH_SIGN && sign_ch) begin
					neg_nx   = (char_code == CH_MINUS);
					phase_nx = PH_INT;
				end else if (is_dig) begin
					phase_nx = PH_INT;
					if (mant_ok) begin
						mant_nx = mant_push;
					end else begin
						ovf_nx = 1'b1;
					end
				end else if (char_code == CH_DOT) begin
					phase_nx = PH_FRAC;
				end else if (exp_ch) begin
					phase_nx = PH_ESIGN;
				end else begin
					phase_nx = PH_STOP;
				end
			end
			PH_FRAC: begin
				if (is_dig) begin
					if (fd_q != dtfp_pkg::FDIG_W'(dtfp_pkg::FDIG_MAX) && mant_ok) begin
						mant_nx = mant_push;
						fd_nx   = fd_q + dtfp_pkg::FDIG_W'(1);
					end
				end else if (exp_ch) begin
					phase_nx = PH_ESIGN;
				end else begin
					phase_nx = PH_STOP;
				end
			end
			PH_ESIGN, PH_EDIG: begin
				if (phase_q == PH_ESIGN && sign_ch) begin
					eneg_nx  = (char_code == CH_MINUS);
					phase_nx = PH_EDIG;
				end else if (is_dig) begin
					phase_nx = PH_EDIG;
					emag_nx  = (emag_calc > EM_W'(dtfp_pkg::EXPM_MAX))
						? dtfp_pkg::EXPM_W'(dtfp_pkg::EXPM_MAX) : emag_calc[dtfp_pkg::EXPM_W-1:0];
				end else begin
					phase_nx = PH_STOP;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIGN;
			neg_q   <= 1'b0;
			mant_q  <= '0;
			fd_q    <= '0;
			eneg_q  <= 1'b0;
			emag_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (last_char) begin
				phase_q <= PH_SIGN;
				neg_q   <= 1'b0;
				mant_q  <= '0;
				fd_q    <= '0;
				eneg_q  <= 1'b0;
				emag_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_nx;
				neg_q   <= neg_nx;
				mant_q  <= mant_nx;
				fd_q    <= fd_nx;
				eneg_q  <= eneg_nx;
				emag_q  <= emag_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	assign push         = take && last_char;
	assign job.neg      = neg_nx;
	assign job.ovf      = ovf_nx;
	assign job.exp_neg  = eneg_nx;
	assign job.exp_mag  = emag_nx;
	assign job.frac_dig = fd_nx;
	assign job.mant     = mant_nx;

endmodule

>>> rtl/core/dtfp_queue.sv
// ----------------------------------------------------------------------------
// dtfp_queue
// Short job queue between parser and scaler.
// ----------------------------------------------------------------------------
`include "decimal_text_to_fixed_point_macros.svh"

module dtfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dtfp_pkg::job_t    job_in,
	output logic              full,
	input  logic              pop,
	output logic              job_valid,
	output dtfp_pkg::job_t    job_out
);

	dtfp_pkg::job_t                 fifo_q [dtfp_pkg::Q_DEPTH];
	logic [dtfp_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [dtfp_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [dtfp_pkg::Q_AW:0]        count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full      = (count_q == (dtfp_pkg::Q_AW+1)'(dtfp_pkg::Q_DEPTH));
	assign job_valid = (count_q != '0);
	assign job_out   = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && job_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + dtfp_pkg::Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + dtfp_pkg::Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (dtfp_pkg::Q_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (dtfp_pkg::Q_AW+1)'(1);
			end
		end
	end

	`DTFP_ASSERT(a_q_no_push_full, push |-> !full, "job pushed into full queue")
	`DTFP_ASSERT_NEXT(a_q_count_up, push && !full && !pop, count_q != '0, "push lost")

endmodule

>>> rtl/core/dtfp_back.sv
// ----------------------------------------------------------------------------
// dtfp_back
// Scaler: mantissa x 10^e x 2^FRAC_BITS by iterated x10 or restoring division,
// then clamp, sign and output register.
// ----------------------------------------------------------------------------
`include "decimal_text_to_fixed_point_macros.svh"

module dtfp_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	input  dtfp_pkg::job_t                   job,
	output logic                             pop,
	output logic                             m_valid,
	input  logic                             m_ready,
	output logic [dtfp_pkg::VALUE_W-1:0]     value,
	output logic                             saturated
);

	localparam int VW = dtfp_pkg::VALUE_W;
	localparam int AW = dtfp_pkg::ACC_W;
	localparam int DW = dtfp_pkg::DIV_W;
	localparam int EW = dtfp_pkg::EXP_W;
	localparam logic [VW-1:0] POS_LIM = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] NEG_LIM = {1'b1, {(VW-1){1'b0}}};
	localparam logic [VW-1:0] POS_D10 = POS_LIM / 10;
	localparam logic [VW-1:0] NEG_D10 = NEG_LIM / 10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                         state_q;
	logic                           neg_q;
	logic                           sat_q;
	logic [VW-1:0]                  mag_q;
	logic [AW-1:0]                  acc_q;
	logic [DW-1:0]                  rem_q;
	logic [DW-1:0]                  div_q;
	logic [dtfp_pkg::CNT_W-1:0]     cnt_q;
	logic                           m_valid_q;
	logic [VW-1:0]                  value_q;
	logic                           sat_out_q;

	logic [EW-1:0]                  e_u;
	logic [EW-1:0]                  k_full;
	logic [dtfp_pkg::KI_W-1:0]      k_idx;
	logic [AW-1:0]                  num_init;
	logic [VW-1:0]                  lim;
	logic [VW-1:0]                  lim_d10;
	logic [VW-1:0]                  lim_shr;
	logic [AW-1:0]                  mul_mag;
	logic [DW:0]                    rem_sh;
	logic                           ge;
	logic [DW:0]                    rem_nx;
	logic [VW-1:0]                  fin_mag;

	always_comb begin
		e_u = (job.exp_neg ? (EW'(0) - EW'(job.exp_mag)) : EW'(job.exp_mag))
			- EW'(job.frac_dig);
		k_full   = EW'(0) - e_u;
		k_idx    = (k_full > EW'(dtfp_pkg::K_MAX)) ? dtfp_pkg::KI_W'(dtfp_pkg::K_MAX)
			: k_full[dtfp_pkg::KI_W-1:0];
		num_init = AW'(job.mant) << dtfp_pkg::FRAC_BITS;

		lim     = neg_q ? NEG_LIM : POS_LIM;
		lim_d10 = neg_q ? NEG_D10 : POS_D10;
		lim_shr = lim >> dtfp_pkg::FRAC_BITS;
		mul_mag = acc_q << dtfp_pkg::FRAC_BITS;

		rem_sh = {rem_q, acc_q[AW-1]};
		ge     = rem_sh >= {1'b0, div_q};
		rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

		fin_mag = sat_q ? lim : mag_q;
	end

	assign pop = (state_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			neg_q     <= 1'b0;
			sat_q     <= 1'b0;
			mag_q     <= '0;
			acc_q     <= '0;
			rem_q     <= '0;
			div_q     <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			value_q   <= '0;
			sat_out_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!m_valid_q || m_ready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						neg_q <= job.neg;
						sat_q <= job.ovf;
						mag_q <= '0;
						if (job.ovf) begin
							state_q <= ST_FIN;
						end else if (job.mant == '0) begin
							state_q <= ST_FIN;
						end else if (!e_u[EW-1]) begin
							acc_q   <= AW'(job.mant);
							cnt_q   <= dtfp_pkg::CNT_W'(e_u[dtfp_pkg::EXPM_W-1:0]);
							state_q <= ST_MUL;
						end else begin
							acc_q   <= num_init;
							rem_q   <= '0;
							div_q   <= dtfp_pkg::POW10[k_idx];
							cnt_q   <= dtfp_pkg::CNT_W'(AW);
							state_q <= ST_DIV;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						if (acc_q > AW'(lim_shr)) begin
							sat_q <= 1'b1;
						end else begin
							mag_q <= mul_mag[VW-1:0];
						end
						state_q <= ST_FIN;
					end else if (acc_q > AW'(lim_d10)) begin
						sat_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						acc_q <= (acc_q << 3) + (acc_q << 1);
						cnt_q <= cnt_q - dtfp_pkg::CNT_W'(1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (acc_q > AW'(lim)) begin
							sat_q <= 1'b1;
						end else begin
							mag_q <= acc_q[VW-1:0];
						end
						state_q <= ST_FIN;
					end else begin
						rem_q <= rem_nx[DW-1:0];
						acc_q <= {acc_q[AW-2:0], ge};
						cnt_q <= cnt_q - dtfp_pkg::CNT_W'(1);
					end
				end
				ST_FIN: begin
					if (!m_valid_q || m_ready) begin
						value_q   <= neg_q ? (VW'(0) - fin_mag) : fin_mag;
						sat_out_q <= sat_q;
						state_q   <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign m_valid   = m_valid_q;
	assign value     = value_q;
	assign saturated = sat_out_q;

	`DTFP_ASSERT(a_sat_clamped, (m_valid_q && sat_out_q) |-> (value_q == POS_LIM || value_q == NEG_LIM), "saturated result not at a limit")
	`DTFP_ASSERT(a_valid_from_fin, $rose(m_valid_q) |-> $past(state_q == ST_FIN), "result raised outside final state")
	`DTFP_ASSERT_NEXT(a_div_runs, state_q == ST_DIV && cnt_q != '0, state_q == ST_DIV, "division left early")

endmodule
